[rtl/mep_pkg.sv]
// Package with shared types and constants for the Mandelbrot escape-time pixel block.
`default_nettype none
package mep_pkg;
  localparam int unsigned REG_COLUMNS = 0;
  localparam int unsigned REG_MAX_ITER = 1;
  localparam int unsigned REG_X_ORIGIN = 2;
  localparam int unsigned REG_Y_ORIGIN = 3;
  localparam int unsigned REG_X_SPAN = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned MAX_COLUMNS = 4096;

  typedef struct packed {
    logic [11:0] row;
    logic [11:0] col;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] iteration_count;
    logic [7:0] shade;
  } pixel_out_t;
endpackage
`default_nettype wire

[rtl/mep_divider.sv]
// Restoring divider, one quotient bit per cycle, used for step and shade.
`default_nettype none
module mep_divider #(
  parameter int unsigned NW = 31,
  parameter int unsigned DW = 13
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo
);
  localparam int unsigned CW = $clog2(NW + 1);
  logic [NW-1:0] rem_hi;
  logic [NW-1:0] n_sh;
  logic [DW-1:0] d;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [NW:0]   trial;
  logic [NW:0]   sub;

  always_comb begin
    trial = {rem_hi, n_sh[NW-1]};
    sub = trial - {{(NW + 1 - DW){1'b0}}, d};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CW'(NW);
      rem_hi <= '0;
      n_sh <= num;
      d <= den;
    end else if (busy) begin
      if (!sub[NW]) begin
        rem_hi <= sub[NW-1:0];
      end else begin
        rem_hi <= trial[NW-1:0];
      end
      n_sh <= {n_sh[NW-2:0], 1'b0};
      quo <= {quo[NW-2:0], ~sub[NW]};
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

[rtl/mep_front.sv]
// Front end: accepts pixels and maps them to complex points.
`default_nettype none
module mep_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mep_pkg::pixel_in_t in_word,
  input  wire logic [12:0]        columns,
  input  wire logic [30:0]        x_span,
  input  wire logic [31:0]        x_origin,
  input  wire logic [31:0]        y_origin,
  output logic                    pt_valid,
  input  wire logic               pt_stall,
  output logic [63:0]             pt_data
);
  import mep_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_ADD, S_OUT} state_t;
  state_t state;
  logic [11:0] row_q, col_q;
  logic        div_start, div_done;
  logic [30:0] step_q, quo;
  logic [42:0] pre_re, pre_im;
  logic [12:0] cols;
  logic signed [44:0] sum_re, sum_im;

  assign cols = (columns == '0) ? 13'd1 : columns;
  assign in_stall = (state != S_IDLE);
  assign div_start = (state == S_IDLE) && in_valid;

  mep_divider #(.NW(31), .DW(13)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(x_span), .den(cols),
    .done(div_done), .quo(quo)
  );

  function automatic logic [31:0] sat32(input logic signed [44:0] v);
    if (v > 45'sh0_7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end else if (v < -45'sh0_8000_0000) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  always_comb begin
    sum_re = $signed({{13{x_origin[31]}}, x_origin}) + $signed({2'b0, pre_re});
    sum_im = $signed({{13{y_origin[31]}}, y_origin}) + $signed({2'b0, pre_im});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pt_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            row_q <= in_word.row;
            col_q <= in_word.col;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            step_q <= quo;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          pre_re <= 43'(col_q * step_q);
          pre_im <= 43'(row_q * step_q);
          state <= S_ADD;
        end
        S_ADD: begin
          pt_data <= {sat32(sum_re), sat32(sum_im)};
          pt_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!pt_stall) begin
            pt_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/mep_queue.sv]
// Two-entry queue between the front and back ends.
`default_nettype none
module mep_queue #(
  parameter int unsigned W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_valid,
  output logic              wr_stall,
  input  wire logic [W-1:0] wr_data,
  output logic              rd_valid,
  input  wire logic         rd_stall,
  output logic [W-1:0]      rd_data
);
  logic [W-1:0] mem [2];
  logic         wp, rp;
  logic [1:0]   fill;
  logic         push, pop;

  assign wr_stall = (fill == 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_data = mem[rp];
  assign push = wr_valid && !wr_stall;
  assign pop = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wr_data;
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

[rtl/mep_back.sv]
// Back end: iterates z = z*z + c and forms the count and shade.
`default_nettype none
module mep_back #(
  parameter int unsigned FRAC_BITS = 28,
  parameter int unsigned ITER_LIMIT_MAX = 255
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                pt_valid,
  output logic                     pt_stall,
  input  wire logic [63:0]         pt_data,
  input  wire logic [7:0]          max_iterations,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mep_pkg::pixel_out_t      out_word
);
  import mep_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ADD, S_SHADE, S_DIV, S_OUT} state_t;
  state_t state;
  logic signed [31:0] c_re, c_im, zr, zi;
  logic signed [63:0] p_rr, p_ii, p_ri;
  logic [7:0]  lim, cnt;
  logic [7:0]  lim_cfg;
  logic signed [65:0] zr2, zi2, zri, nr, ni, norm;
  logic        div_start, div_done;
  logic [15:0] quo;
  logic [15:0] shade_num;

  assign lim_cfg = (max_iterations == '0) ? 8'd1 :
                   ({24'd0, max_iterations} > ITER_LIMIT_MAX) ? 8'(ITER_LIMIT_MAX) :
                   max_iterations;
  assign pt_stall = (state != S_IDLE);

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sh7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -66'sh8000_0000) begin
      return -32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  always_comb begin
    zr2 = $signed({{2{p_rr[63]}}, p_rr}) >>> FRAC_BITS;
    zi2 = $signed({{2{p_ii[63]}}, p_ii}) >>> FRAC_BITS;
    zri = $signed({{2{p_ri[63]}}, p_ri}) >>> (FRAC_BITS - 1);
    norm = zr2 + zi2;
    nr = zr2 - zi2 + {{34{c_re[31]}}, c_re};
    ni = zri + {{34{c_im[31]}}, c_im};
  end

  assign shade_num = 16'(8'd255 * (lim - cnt));
  assign div_start = (state == S_SHADE);

  mep_divider #(.NW(16), .DW(8)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(shade_num), .den(lim),
    .done(div_done), .quo(quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (pt_valid) begin
            c_re <= pt_data[63:32];
            c_im <= pt_data[31:0];
            lim <= lim_cfg;
            cnt <= '0;
            p_rr <= '0;
            p_ii <= '0;
            p_ri <= '0;
            state <= S_ADD;
          end
        end
        S_ADD: begin
          if (cnt != '0 && (cnt >= lim || norm >= (66'sd4 <<< FRAC_BITS))) begin
            state <= S_SHADE;
          end else if (cnt >= lim) begin
            state <= S_SHADE;
          end else begin
            zr <= sat32(nr);
            zi <= sat32(ni);
            cnt <= cnt + 1'b1;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          p_rr <= zr * zr;
          p_ii <= zi * zi;
          p_ri <= zr * zi;
          state <= S_ADD;
        end
        S_SHADE: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            out_word.iteration_count <= cnt;
            out_word.shade <= quo[7:0];
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/mandelbrot_escape_pixel.sv]
// Top level of the Mandelbrot escape-time pixel evaluator.
// Each pixel passes through the front end, which does a bit-serial step
// division and the coordinate products, then through a two-word queue to the
// back end, which runs the complex iterations through its three multipliers
// and then a shade division. The queue lets the front end map the next pixel
// while the back end iterates.
`default_nettype none
module mandelbrot_escape_pixel #(
  parameter int unsigned FRAC_BITS = 28,
  parameter int unsigned ITER_LIMIT_MAX = 255
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire mep_pkg::pixel_in_t                 in_word,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output mep_pkg::pixel_out_t                     out_word,
  input  wire logic                               cfg_we,
  input  wire logic [mep_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mep_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mep_pkg::*;
  logic [12:0] columns;
  logic [7:0]  max_iterations;
  logic [31:0] x_origin, y_origin;
  logic [30:0] x_span;
  logic        f_valid, f_stall, q_valid, q_stall;
  logic [63:0] f_data, q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= 13'd640;
      max_iterations <= 8'd50;
      x_origin <= 32'hE000_0000;
      y_origin <= 32'hF000_0000;
      x_span <= 31'h3000_0000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_W'(REG_COLUMNS): columns <= cfg_data[12:0];
        CFG_IDX_W'(REG_MAX_ITER): max_iterations <= cfg_data[7:0];
        CFG_IDX_W'(REG_X_ORIGIN): x_origin <= cfg_data;
        CFG_IDX_W'(REG_Y_ORIGIN): y_origin <= cfg_data;
        CFG_IDX_W'(REG_X_SPAN): x_span <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  mep_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .columns(columns), .x_span(x_span), .x_origin(x_origin), .y_origin(y_origin),
    .pt_valid(f_valid), .pt_stall(f_stall), .pt_data(f_data)
  );

  mep_queue #(.W(64)) u_queue (
    .clk(clk), .rst(rst), .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_data),
    .rd_valid(q_valid), .rd_stall(q_stall), .rd_data(q_data)
  );

  mep_back #(.FRAC_BITS(FRAC_BITS), .ITER_LIMIT_MAX(ITER_LIMIT_MAX)) u_back (
    .clk(clk), .rst(rst), .pt_valid(q_valid), .pt_stall(q_stall), .pt_data(q_data),
    .max_iterations(max_iterations), .out_valid(out_valid), .out_stall(out_stall),
    .out_word(out_word)
  );
endmodule
`default_nettype wire
